### src/cu_pkg.sv
package cu_pkg;

  localparam int RANK_W  = 30;
  localparam int N_W     = 6;
  localparam int K_W     = 5;
  localparam int ELEM_W  = 5;
  localparam int DEF_MAX_N = 32;
  localparam int DEF_MAX_K = 16;

  localparam int TBL_AW    = N_W + K_W;
  localparam int TBL_DEPTH = 1 << TBL_AW;
  localparam int TBL_COLS  = 1 << K_W;

  // Register indexes on the configuration port.
  localparam logic REG_SET_SIZE    = 1'b0;
  localparam logic REG_SUBSET_SIZE = 1'b1;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [N_W-1:0]    n;
    logic [K_W-1:0]    k;
    logic              bad;
  } cu_job_t;

  typedef logic [RANK_W-1:0] binom_tbl_t [0:TBL_DEPTH-1];

  // Pascal triangle, indexed {n, r}; rows above max_n read as zero.
  function automatic binom_tbl_t binom_build(input int max_n);
    binom_tbl_t t;
    int a;
    int r;
    for (a = 0; a < (1 << N_W); a++) begin
      for (r = 0; r < TBL_COLS; r++) begin
        if (a > max_n) begin
          t[a*TBL_COLS + r] = '0;
        end else if (r == 0) begin
          t[a*TBL_COLS + r] = RANK_W'(1);
        end else if (a == 0) begin
          t[a*TBL_COLS + r] = '0;
        end else begin
          t[a*TBL_COLS + r] = t[(a-1)*TBL_COLS + r - 1] + t[(a-1)*TBL_COLS + r];
        end
      end
    end
    return t;
  endfunction

endpackage

### src/cu_front.sv
module cu_front import cu_pkg::*; #(
  parameter int MAX_N = DEF_MAX_N,
  parameter int MAX_K = DEF_MAX_K
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [RANK_W-1:0] in_rank,
  input  logic [N_W-1:0]    set_size,
  input  logic [K_W-1:0]    subset_size,
  input  logic              q_full,
  output logic              q_push,
  output cu_job_t           q_job
);

  logic bad;

  // Flag requests that can be rejected without the table.
  always_comb begin
    bad = (set_size == '0) || (subset_size == '0) ||
          (set_size > N_W'(MAX_N)) || (subset_size > K_W'(MAX_K)) ||
          ({1'b0, subset_size} > set_size);
  end

  assign in_ready   = !q_full && !rst;
  assign q_push     = in_valid && in_ready;
  assign q_job.rank = in_rank;
  assign q_job.n    = set_size;
  assign q_job.k    = subset_size;
  assign q_job.bad  = bad;

  logic unused_clk;
  assign unused_clk = clk;

endmodule

### src/cu_queue.sv
module cu_queue import cu_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cu_job_t push_job,
  input  logic    pop,
  output cu_job_t pop_job,
  output logic    full,
  output logic    empty
);

  cu_job_t    slots [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

### src/cu_back.sv
module cu_back import cu_pkg::*; #(
  parameter int MAX_N = DEF_MAX_N
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  output logic              q_pop,
  input  cu_job_t           q_job,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ELEM_W-1:0] out_element,
  output logic              out_last,
  output logic              out_error
);

  localparam binom_tbl_t BINOM = binom_build(MAX_N);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PRECHK = 6'b000010,
    S_CHK    = 6'b000100,
    S_STEPA  = 6'b001000,
    S_STEPB  = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t             st;
  logic [RANK_W-1:0]  rank;
  logic [N_W-1:0]     n;
  logic [K_W-1:0]     k;
  logic [ELEM_W-1:0]  cand;
  logic [K_W-2:0]     m;
  logic               err;
  logic [RANK_W-1:0]  rom_q;
  logic [TBL_AW-1:0]  addr;
  logic [N_W-1:0]     cand_inc;
  logic               out_free;
  logic               is_last;

  assign cand_inc = {1'b0, cand} + N_W'(1);
  assign out_free = !out_valid || out_ready;
  assign is_last  = err || ({1'b0, m} + K_W'(1) == k);
  assign q_pop    = (st == S_IDLE) && !q_empty;

  // Table address: full C(n,k) for the range check, else the skip block size.
  always_comb begin
    if (st == S_PRECHK) begin
      addr = {n, k};
    end else begin
      addr = {n - cand_inc, k - K_W'(1) - {1'b0, m}};
    end
  end

  always_ff @(posedge clk) begin
    rom_q <= BINOM[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((st == S_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (!q_empty) begin
            rank <= q_job.rank;
            n    <= q_job.n;
            k    <= q_job.k;
            cand <= '0;
            m    <= '0;
            err  <= q_job.bad;
            st   <= q_job.bad ? S_EMIT : S_PRECHK;
          end
        end
        S_PRECHK: st <= S_CHK;
        S_CHK: begin
          if (rank >= rom_q) begin
            err <= 1'b1;
            st  <= S_EMIT;
          end else begin
            st <= S_STEPA;
          end
        end
        S_STEPA: st <= (cand_inc < n) ? S_STEPB : S_EMIT;
        S_STEPB: begin
          if (rank < rom_q) begin
            st <= S_EMIT;
          end else begin
            rank <= rank - rom_q;
            cand <= cand + ELEM_W'(1);
            st   <= S_STEPA;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_element <= err ? '0 : cand;
            out_last    <= is_last;
            out_error   <= err;
            cand        <= cand + ELEM_W'(1);
            m           <= m + (K_W-1)'(1);
            st          <= is_last ? S_IDLE : S_STEPA;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

### src/combination_unrank_top.sv
// The back end unranks one request at a time: a range check against C(N,K), then
// a walk that skips candidates and emits elements, paced by the single registered
// port of the binomial table. The two-deep queue takes further ranks meanwhile.
// Reset (rst, synchronous, active high) empties the queue and the output
// register and sets N to 32, K to 1.
module combination_unrank_top import cu_pkg::*; #(
  parameter int MAX_N = DEF_MAX_N,
  parameter int MAX_K = DEF_MAX_K
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream: tdata[29:0] rank_index, tdata[31:30] zero.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,
  // Output stream: tdata[4:0] element, tdata[7:5] zero; tlast last; tuser error.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,
  output logic        m_tlast,
  output logic        m_tuser,
  // Configuration: 0x0 set_size, 0x4 subset_size.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [N_W-1:0]    set_size;
  logic [K_W-1:0]    subset_size;
  logic              cfg_wr;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  cu_job_t           push_job;
  cu_job_t           pop_job;
  logic [ELEM_W-1:0] element;

  // Configuration registers; low address bits are not decoded.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_size    <= N_W'(32);
      subset_size <= K_W'(1);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_SET_SIZE:    set_size    <= pwdata[N_W-1:0];
        REG_SUBSET_SIZE: subset_size <= pwdata[K_W-1:0];
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_SUBSET_SIZE) ? {27'd0, subset_size} : {26'd0, set_size};

  // Front end: take the beat and flag requests that are plainly invalid.
  cu_front #(.MAX_N(MAX_N), .MAX_K(MAX_K)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_rank     (s_tdata[RANK_W-1:0]),
    .set_size    (set_size),
    .subset_size (subset_size),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (push_job)
  );

  // Two-deep queue decouples intake from the unranking walk.
  cu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back end: range check against C(N,K), then walk the candidates.
  cu_back #(.MAX_N(MAX_N)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_job       (pop_job),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_element (element),
    .out_last    (m_tlast),
    .out_error   (m_tuser)
  );

  assign m_tdata = {3'd0, element};

  logic unused_pad;
  assign unused_pad = ^{s_tdata[31:RANK_W], pwdata[31:N_W], paddr[1:0]};

endmodule

### src/cu_checker.sv
module cu_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic       m_tuser,
  input logic       pready
);

  // Hold a stalled beat.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output beat changed");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'd0))
    else $error("error beat not a single zero element");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind combination_unrank_top cu_checker u_cu_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser),
  .pready   (pready)
);
